// ===== rtl/core/mcbt_pkg.sv =====
package mcbt_pkg;

    localparam int ADDR_W      = 30;
    localparam int IDX_W       = 7;
    localparam int CNT_W       = 8;
    localparam int ACT_W       = 3;
    localparam int KIND_W      = 3;
    localparam int QUEUE_DEPTH = 4;

    // action codes on the input channel
    localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MARK      = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SWEEP     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TRANSLATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ      = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_XLATE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 3'd4;

    // register indexes
    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_HEAP_END  = 1'b1;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_MARK,
        OP_SWEEP,
        OP_TRANSLATE,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] address;
        logic [IDX_W-1:0]  index;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] source;
        logic [ADDR_W-1:0] destination;
        logic [ADDR_W-1:0] length;
        logic [CNT_W-1:0]  count;
        logic              overflow;
        logic              last;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/core/mcbt_front.sv =====
module mcbt_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // address[29:0], index[36:30], zero pad
    input  logic [mcbt_pkg::ACT_W-1:0]   s_tuser,   // action[2:0]
    input  mcbt_pkg::qstat_t             q_stat,
    output logic                         q_push,
    output mcbt_pkg::cmd_t               q_cmd
);
    import mcbt_pkg::*;

    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && !q_stat.full;

    // classify the action into an operation for the back end
    always_comb begin
        q_cmd.address = s_tdata[ADDR_W-1:0];
        q_cmd.index   = s_tdata[ADDR_W+IDX_W-1:ADDR_W];
        case (s_tuser)
            ACT_CLEAR:     q_cmd.op = OP_CLEAR;
            ACT_APPEND:    q_cmd.op = OP_APPEND;
            ACT_MARK:      q_cmd.op = OP_MARK;
            ACT_SWEEP:     q_cmd.op = OP_SWEEP;
            ACT_TRANSLATE: q_cmd.op = OP_TRANSLATE;
            ACT_READ:      q_cmd.op = OP_READ;
            default:       q_cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/core/mcbt_queue.sv =====
module mcbt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mcbt_pkg::cmd_t   push_cmd,
    input  logic             pop,
    output mcbt_pkg::qstat_t stat,
    output mcbt_pkg::cmd_t   head
);
    import mcbt_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    assign stat.full  = (fill_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? PW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? PW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = CW'(fill_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            fill_next = CW'(fill_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/mcbt_back.sv =====
module mcbt_back #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [mcbt_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  mcbt_pkg::qstat_t              q_stat,
    input  mcbt_pkg::cmd_t                q_head,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,  // source, destination, length, count,
                                                    // overflow, zero pad
    output logic [mcbt_pkg::KIND_W-1:0]   m_tuser,  // kind[2:0]
    output logic                          m_tlast
);
    import mcbt_pkg::*;

    localparam int RUN_DEPTH = MAX_BLOCKS / 2;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int RA = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int RW = $clog2(RUN_DEPTH + 1);

    typedef struct packed {
        logic [ADDR_W-1:0] old_start;
        logic [ADDR_W-1:0] old_end;
        logic [ADDR_W:0]   offset;
    } run_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_MK_RD,
        ST_MK_CMP,
        ST_SW_LEAD,
        ST_SW_ENDB,
        ST_SW_SKIP,
        ST_SW_START,
        ST_SW_RUN,
        ST_SW_MOVE,
        ST_SW_REND,
        ST_SW_REC,
        ST_TR_RD,
        ST_TR_CMP,
        ST_RE_WAIT
    } state_t;

    // memories
    logic [ADDR_W-1:0] blk_mem [MAX_BLOCKS];
    run_t              run_mem [RUN_DEPTH];
    logic [ADDR_W-1:0] blk_rd_data;
    run_t              run_rd_data;
    logic [IW-1:0]     blk_rd_addr, blk_wr_addr;
    logic [ADDR_W-1:0] blk_wr_data;
    logic              blk_we;
    logic [RA-1:0]     run_rd_addr;
    run_t              run_wr_data;
    logic              run_we;

    state_t                state_reg, state_next;
    state_t                ret_reg, ret_next;
    op_t                   op_reg, op_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [CW-1:0]         total_reg, total_next;
    logic [RW-1:0]         run_total_reg, run_total_next;
    logic [MAX_BLOCKS-1:0] mark_reg, mark_next;
    logic [CW-1:0]         lo_reg, lo_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         g_reg, g_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         clean_reg, clean_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [ADDR_W-1:0]     endb_reg, endb_next;
    logic [ADDR_W-1:0]     startb_reg, startb_next;
    logic [ADDR_W-1:0]     runend_reg, runend_next;
    logic [ADDR_W:0]       off_reg, off_next;
    logic [ADDR_W-1:0]     heap_base_reg, heap_base_next;
    logic [ADDR_W-1:0]     heap_end_reg, heap_end_next;
    res_t                  res_reg, res_next;
    res_t                  m_res_reg, m_res_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  out_free;
    logic [CW-1:0]         lo_v, hi_v;
    logic                  i_live;

    assign out_free = !m_valid_reg || m_tready;
    assign i_live   = (i_reg < total_reg);
    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last;
    assign m_tdata  = {5'b0, m_res_reg.overflow, m_res_reg.count, m_res_reg.length,
                       m_res_reg.destination, m_res_reg.source};

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        run_total_next = run_total_reg;
        mark_next      = mark_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        g_next         = g_reg;
        i_next         = i_reg;
        clean_next     = clean_reg;
        r_next         = r_reg;
        endb_next      = endb_reg;
        startb_next    = startb_reg;
        runend_next    = runend_reg;
        off_next       = off_reg;
        heap_base_next = heap_base_reg;
        heap_end_next  = heap_end_reg;
        res_next       = res_reg;
        m_res_next     = m_res_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        lo_v           = lo_reg;
        hi_v           = hi_reg;
        blk_rd_addr    = '0;
        blk_we         = 1'b0;
        blk_wr_addr    = '0;
        blk_wr_data    = '0;
        run_rd_addr    = '0;
        run_we         = 1'b0;
        run_wr_data    = '0;

        if (cfg_wr_en) begin
            if (cfg_index == REG_HEAP_BASE) begin
                heap_base_next = cfg_wr_data;
            end else begin
                heap_end_next = cfg_wr_data;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    op_next    = q_head.op;
                    addr_next  = q_head.address;
                    idx_next   = q_head.index;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                res_next = '{kind: KIND_ACK, source: '0, destination: '0, length: '0,
                             count: CNT_W'(total_reg), overflow: 1'b0, last: 1'b1};
                state_next = ST_EMIT;
                case (op_reg)
                    OP_CLEAR: begin
                        total_next     = '0;
                        run_total_next = '0;
                        mark_next      = '0;
                        res_next.count = '0;
                    end
                    OP_APPEND: begin
                        if (total_reg < CW'(MAX_BLOCKS)) begin
                            blk_we         = 1'b1;
                            blk_wr_addr    = total_reg[IW-1:0];
                            blk_wr_data    = addr_reg;
                            mark_next[total_reg[IW-1:0]] = 1'b0;
                            total_next     = CW'(total_reg + 1'b1);
                            res_next.count = CNT_W'(CW'(total_reg + 1'b1));
                        end else begin
                            res_next.overflow = 1'b1;
                        end
                    end
                    OP_MARK: begin
                        // ignore pointers outside the heap or an empty table
                        if (!(addr_reg < heap_base_reg || addr_reg >= heap_end_reg ||
                              total_reg == '0)) begin
                            lo_next    = '0;
                            hi_next    = total_reg;
                            state_next = ST_MK_RD;
                        end
                    end
                    OP_SWEEP: begin
                        i_next         = '0;
                        run_total_next = '0;
                        state_next     = ST_SW_LEAD;
                    end
                    OP_TRANSLATE: begin
                        r_next     = '0;
                        state_next = ST_TR_RD;
                    end
                    OP_READ: begin
                        res_next.kind = KIND_ENTRY;
                        if ({1'b0, idx_reg} < CNT_W'(total_reg)) begin
                            blk_rd_addr = idx_reg[IW-1:0];
                            state_next  = ST_RE_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_res_next   = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = res_reg.last ? ST_IDLE : ret_reg;
                end
            end

            ST_MK_RD: begin
                g_next      = CW'(lo_reg + ((hi_reg - lo_reg) >> 1));
                blk_rd_addr = g_next[IW-1:0];
                state_next  = ST_MK_CMP;
            end

            ST_MK_CMP: begin
                if (addr_reg == blk_rd_data) begin
                    mark_next[g_reg[IW-1:0]] = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    if (addr_reg > blk_rd_data) begin
                        lo_v = g_reg;
                    end else begin
                        hi_v = g_reg;
                    end
                    lo_next = lo_v;
                    hi_next = hi_v;
                    if (CW'(hi_v - lo_v) > CW'(1)) begin
                        state_next = ST_MK_RD;
                    end else begin
                        mark_next[lo_v[IW-1:0]] = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SW_LEAD: begin
                // leading marked blocks stay in place
                if (i_live && mark_reg[i_reg[IW-1:0]]) begin
                    i_next = CW'(i_reg + 1'b1);
                end else begin
                    clean_next = i_reg;
                    if (i_live) begin
                        blk_rd_addr = i_reg[IW-1:0];
                        state_next  = ST_SW_ENDB;
                    end else begin
                        endb_next  = heap_end_reg;
                        state_next = ST_SW_SKIP;
                    end
                end
            end

            ST_SW_ENDB: begin
                endb_next  = blk_rd_data;
                state_next = ST_SW_SKIP;
            end

            ST_SW_SKIP: begin
                if (i_live && !mark_reg[i_reg[IW-1:0]]) begin
                    i_next = CW'(i_reg + 1'b1);
                end else if (!i_live) begin
                    total_next    = clean_reg;
                    heap_end_next = endb_reg;
                    mark_next     = '0;
                    res_next = '{kind: KIND_DONE, source: '0, destination: endb_reg,
                                 length: '0, count: CNT_W'(clean_reg), overflow: 1'b0,
                                 last: 1'b1};
                    state_next = ST_EMIT;
                end else begin
                    blk_rd_addr = i_reg[IW-1:0];
                    state_next  = ST_SW_START;
                end
            end

            ST_SW_START: begin
                startb_next = blk_rd_data;
                off_next    = {1'b0, endb_reg} - {1'b0, blk_rd_data};
                state_next  = ST_SW_RUN;
            end

            ST_SW_RUN: begin
                if (i_live && mark_reg[i_reg[IW-1:0]]) begin
                    blk_rd_addr = i_reg[IW-1:0];
                    state_next  = ST_SW_MOVE;
                end else if (i_live) begin
                    blk_rd_addr = i_reg[IW-1:0];
                    state_next  = ST_SW_REND;
                end else begin
                    runend_next = heap_end_reg;
                    state_next  = ST_SW_REC;
                end
            end

            ST_SW_MOVE: begin
                // slide one block of the run down over the hole
                blk_we      = 1'b1;
                blk_wr_addr = clean_reg[IW-1:0];
                blk_wr_data = blk_rd_data + off_reg[ADDR_W-1:0];
                clean_next  = CW'(clean_reg + 1'b1);
                i_next      = CW'(i_reg + 1'b1);
                state_next  = ST_SW_RUN;
            end

            ST_SW_REND: begin
                runend_next = blk_rd_data;
                state_next  = ST_SW_REC;
            end

            ST_SW_REC: begin
                if (run_total_reg < RW'(RUN_DEPTH)) begin
                    run_we         = 1'b1;
                    run_wr_data    = '{old_start: startb_reg, old_end: runend_reg,
                                       offset: off_reg};
                    run_total_next = RW'(run_total_reg + 1'b1);
                end
                res_next = '{kind: KIND_MOVE, source: startb_reg, destination: endb_reg,
                             length: runend_reg - startb_reg, count: '0, overflow: 1'b0,
                             last: 1'b0};
                endb_next  = runend_reg + off_reg[ADDR_W-1:0];
                ret_next   = ST_SW_SKIP;
                state_next = ST_EMIT;
            end

            ST_TR_RD: begin
                if (r_reg < run_total_reg) begin
                    run_rd_addr = r_reg[RA-1:0];
                    state_next  = ST_TR_CMP;
                end else begin
                    res_next = '{kind: KIND_XLATE, source: addr_reg, destination: '0,
                                 length: '0, count: CNT_W'(total_reg), overflow: 1'b0,
                                 last: 1'b1};
                    state_next = ST_EMIT;
                end
            end

            ST_TR_CMP: begin
                if (addr_reg >= run_rd_data.old_start && addr_reg < run_rd_data.old_end) begin
                    res_next = '{kind: KIND_XLATE,
                                 source: addr_reg + run_rd_data.offset[ADDR_W-1:0],
                                 destination: '0, length: '0, count: CNT_W'(total_reg),
                                 overflow: 1'b0, last: 1'b1};
                    state_next = ST_EMIT;
                end else begin
                    r_next     = RW'(r_reg + 1'b1);
                    state_next = ST_TR_RD;
                end
            end

            ST_RE_WAIT: begin
                res_next.source = blk_rd_data;
                state_next      = ST_EMIT;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            total_reg     <= '0;
            run_total_reg <= '0;
            mark_reg      <= '0;
            heap_base_reg <= '0;
            heap_end_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            total_reg     <= total_next;
            run_total_reg <= run_total_next;
            mark_reg      <= mark_next;
            heap_base_reg <= heap_base_next;
            heap_end_reg  <= heap_end_next;
            m_valid_reg   <= m_valid_next;
        end
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        g_reg      <= g_next;
        i_reg      <= i_next;
        clean_reg  <= clean_next;
        r_reg      <= r_next;
        endb_reg   <= endb_next;
        startb_reg <= startb_next;
        runend_reg <= runend_next;
        off_reg    <= off_next;
        res_reg    <= res_next;
        m_res_reg  <= m_res_next;
    end

    always_ff @(posedge aclk) begin
        if (blk_we) begin
            blk_mem[blk_wr_addr] <= blk_wr_data;
        end
        blk_rd_data <= blk_mem[blk_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (run_we) begin
            run_mem[run_total_reg[RA-1:0]] <= run_wr_data;
        end
        run_rd_data <= run_mem[run_rd_addr];
    end

    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_BLOCKS))
        else $error("block count beyond table size");

    a_clean_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SW_MOVE || state_reg == ST_SW_RUN || state_reg == ST_SW_SKIP)
        |-> clean_reg <= i_reg)
        else $error("compaction write pointer passed read pointer");

    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MK_CMP) |-> (hi_reg > lo_reg && g_reg < total_reg))
        else $error("binary search window collapsed");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_total_reg <= RW'(RUN_DEPTH))
        else $error("run count beyond run table");

endmodule

// ===== rtl/core/mark_compact_block_table.sv =====
// Mark-compact engine over a sorted table of up to MAX_BLOCKS heap block starts
// (word addresses). Send items on the s_ stream with the action in s_tuser; each
// item yields one result on the m_ stream, except sweep, which yields one move
// command per relocated run and then a done item carrying the new heap end and
// block count (m_tlast marks the final result of an item). A four-entry command
// queue parts the accepting front from the executing back end, so items are taken
// while earlier ones still run or their results wait. Items run one at a time in
// the back end; every block table access goes through its single read port (data
// registered). Clear and append write the table directly and read fetches one
// entry; mark does a binary search over the block table; translate checks the runs
// recorded by the last sweep in order; sweep keeps leading marked blocks in place,
// skips unmarked ones and slides each later marked block down, one move per run. A
// stall on m_tready holds the back end. Write heap_base (index 0) and heap_end
// (index 1) only while the block is idle; a sweep rewrites heap_end.
module mark_compact_block_table #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [mcbt_pkg::ADDR_W-1:0]  cfg_wr_data,
    // item input
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // address[29:0], index[36:30], zero pad
    input  logic [mcbt_pkg::ACT_W-1:0]   s_tuser,   // action[2:0]
    // result output
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [103:0]                 m_tdata,   // source[29:0], destination[59:30],
                                                    // length[89:60], count[97:90],
                                                    // overflow[98], zero pad
    output logic [mcbt_pkg::KIND_W-1:0]  m_tuser,   // kind[2:0]
    output logic                         m_tlast
);
    import mcbt_pkg::*;

    qstat_t q_stat;
    cmd_t   q_in_cmd;
    cmd_t   q_head;
    logic   q_push;
    logic   q_pop;

    // decode and accept items into the queue
    mcbt_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_cmd    (q_in_cmd)
    );

    // hold decoded items until the back end is free
    mcbt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in_cmd),
        .pop      (q_pop),
        .stat     (q_stat),
        .head     (q_head)
    );

    // execute table operations and drive the result register
    mcbt_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
